// ===== rtl/core/vrhd_pkg.sv =====
// Shared types, register codes and constants of the vibration RMS detector.
package vrhd_pkg;

  localparam int WINDOW_DEPTH_DEF = 128;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SQ_W = 32;
  localparam int TOTAL_W = 40;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRAVITY_GAIN    = 3'd0,
    REG_NOISE_FLOOR     = 3'd1,
    REG_ON_LEVEL_SQ     = 3'd2,
    REG_OFF_LEVEL_SQ    = 3'd3,
    REG_WINDOW_LENGTH   = 3'd4,
    REG_REPORT_INTERVAL = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] GRAVITY_GAIN_RST = 16'd1311;
  localparam logic [31:0] NOISE_FLOOR_RST = 32'd752;
  localparam logic [31:0] ON_LEVEL_SQ_RST = 32'd419;
  localparam logic [31:0] OFF_LEVEL_SQ_RST = 32'd236;
  localparam logic [7:0] WINDOW_LENGTH_RST = 8'd100;
  localparam logic [7:0] REPORT_INTERVAL_RST = 8'd10;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic        report_valid;
    logic        detect_on;
    logic [38:0] window_total;
    logic [7:0]  window_fill;
  } result_t;

  typedef struct packed {
    logic [15:0] gravity_gain;
    logic [31:0] noise_floor;
    logic [31:0] on_level_sq;
    logic [31:0] off_level_sq;
    logic [7:0]  window_length;
    logic [7:0]  report_interval;
  } cfg_t;

  typedef logic [SQ_W-1:0] square_t;

endpackage

// ===== rtl/core/vrhd_fifo.sv =====
// Small register queue used between the front and back parts and at the result side.
module vrhd_fifo #(
  parameter type word_t = logic,
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t wdata,
  output logic  full,
  input  logic  pop,
  output word_t rdata,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  word_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/vrhd_front.sv =====
// Front part: takes samples, tracks gravity per axis and forms the floored squared magnitude.
module vrhd_front import vrhd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    push,
  input  sample_t sample,
  output logic    full,
  output logic    q_push,
  output square_t q_word,
  input  logic    q_full
);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_UPD, F_SQR, F_SUM} state_t;

  state_t state;
  logic signed [23:0] accel [3];
  logic signed [23:0] grav [3];
  logic gravity_ready;
  logic signed [41:0] prod [3];
  logic signed [24:0] dif [3];
  logic [48:0] sqr [3];

  logic take;
  logic signed [23:0] a24_c [3];
  logic signed [24:0] diff_c [3];
  logic signed [41:0] prod_c [3];
  logic signed [41:0] round_c [3];
  logic signed [23:0] gnew_c [3];
  logic signed [24:0] dnew_c [3];
  logic signed [49:0] sq_c [3];
  logic [50:0] sum_c;
  logic [34:0] scaled_c;
  logic [31:0] sat_c;

  assign full = !((state == F_IDLE) || ((state == F_SUM) && !q_full));
  assign take = push && !full;
  assign q_push = (state == F_SUM) && !q_full;

  always_comb begin
    a24_c[0] = {sample.accel_x, 8'h00};
    a24_c[1] = {sample.accel_y, 8'h00};
    a24_c[2] = {sample.accel_z, 8'h00};
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = {accel[i][23], accel[i]} - {grav[i][23], grav[i]};
      prod_c[i] = $signed({1'b0, cfg.gravity_gain}) * diff_c[i];
      // Round to nearest, then an arithmetic shift takes the floor.
      round_c[i] = prod[i] + 42'sd32768;
      gnew_c[i] = grav[i] + round_c[i][39:16];
      dnew_c[i] = {accel[i][23], accel[i]} - {gnew_c[i][23], gnew_c[i]};
      sq_c[i] = dif[i] * dif[i];
    end
    sum_c = 51'(sqr[0]) + 51'(sqr[1]) + 51'(sqr[2]) + 51'(32768);
    scaled_c = sum_c[50:16];
    sat_c = (|scaled_c[34:32]) ? '1 : scaled_c[31:0];
    q_word = (sat_c < cfg.noise_floor) ? '0 : sat_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      gravity_ready <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        grav[i] <= '0;
      end
    end else begin
      case (state)
        F_MUL: begin
          for (int i = 0; i < 3; i++) begin
            prod[i] <= prod_c[i];
          end
          state <= F_UPD;
        end
        F_UPD: begin
          for (int i = 0; i < 3; i++) begin
            grav[i] <= gnew_c[i];
            dif[i] <= dnew_c[i];
          end
          state <= F_SQR;
        end
        F_SQR: begin
          for (int i = 0; i < 3; i++) begin
            sqr[i] <= sq_c[i][48:0];
          end
          state <= F_SUM;
        end
        F_SUM: begin
          if (q_push) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
      // The first sample seeds the gravity estimate before its own update.
      if (take) begin
        for (int i = 0; i < 3; i++) begin
          accel[i] <= a24_c[i];
          if (!gravity_ready) begin
            grav[i] <= a24_c[i];
          end
        end
        gravity_ready <= 1'b1;
        state <= F_MUL;
      end
    end
  end

endmodule

// ===== rtl/core/vrhd_back.sv =====
// Back part: circular window store, running total, report interval and hysteresis flag.
module vrhd_back import vrhd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    restart,
  input  logic    in_empty,
  input  square_t in_word,
  output logic    in_pop,
  input  logic    out_full,
  output logic    out_push,
  output result_t out_word
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int CMP_W = SLOT_W + 8;

  typedef enum logic [1:0] {B_IDLE, B_ACC, B_EVAL} state_t;

  state_t state;
  square_t store [WINDOW_DEPTH];
  square_t sq_reg;
  square_t old_sq;
  logic [SLOT_W-1:0] slot;
  logic [7:0] fill;
  logic [TOTAL_W-1:0] total;
  logic [7:0] ic;
  logic flag;

  logic [7:0] eff_len_c;
  logic [7:0] intv_c;
  logic slot_wrap_c;
  logic [TOTAL_W-1:0] on_ref_c;
  logic [TOTAL_W-1:0] off_ref_c;
  logic report_c;
  logic det_c;

  assign in_pop = (state == B_IDLE) && !in_empty && !out_full;
  assign out_push = (state == B_EVAL);

  always_comb begin
    if (cfg.window_length == '0) begin
      eff_len_c = 8'd1;
    end else if (CMP_W'(cfg.window_length) > CMP_W'(WINDOW_DEPTH)) begin
      eff_len_c = 8'(WINDOW_DEPTH);
    end else begin
      eff_len_c = cfg.window_length;
    end
    intv_c = (cfg.report_interval == '0) ? 8'd1 : cfg.report_interval;
    slot_wrap_c = (CMP_W'(slot) + CMP_W'(1)) >= CMP_W'(eff_len_c);
    // Compare total against level times fill, which equals comparing the mean.
    on_ref_c = TOTAL_W'(cfg.on_level_sq) * TOTAL_W'(fill);
    off_ref_c = TOTAL_W'(cfg.off_level_sq) * TOTAL_W'(fill);
    report_c = (ic >= intv_c);
    det_c = flag;
    if (report_c) begin
      if (!flag && (total > on_ref_c)) begin
        det_c = 1'b1;
      end else if (flag && (total < off_ref_c)) begin
        det_c = 1'b0;
      end
    end
    out_word.report_valid = report_c;
    out_word.detect_on = det_c;
    out_word.window_total = total[38:0];
    out_word.window_fill = fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      slot <= '0;
      fill <= '0;
      total <= '0;
      ic <= '0;
      flag <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (in_pop) begin
            sq_reg <= in_word;
            state <= B_ACC;
          end
        end
        B_ACC: begin
          if (fill < eff_len_c) begin
            fill <= fill + 1'b1;
            total <= total + TOTAL_W'(sq_reg);
          end else begin
            total <= total - TOTAL_W'(old_sq) + TOTAL_W'(sq_reg);
          end
          slot <= slot_wrap_c ? '0 : slot + 1'b1;
          ic <= ic + 1'b1;
          state <= B_EVAL;
        end
        B_EVAL: begin
          if (report_c) begin
            ic <= '0;
            flag <= det_c;
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
      if (restart) begin
        slot <= '0;
        fill <= '0;
        total <= '0;
      end
    end
  end

  // The entry leaving the window is read while the new value is fetched.
  always_ff @(posedge clk) begin
    if (state == B_ACC) begin
      store[slot] <= sq_reg;
    end
    old_sq <= store[slot];
  end

endmodule

// ===== rtl/core/vibration_rms_hysteresis_detector.sv =====
// Top level of the vibration detector: configuration registers, front, queues and back.
// Each word pushed is one three-axis acceleration sample in signed Q8.8. A low-pass
// gravity estimate per axis (Q8.16) is seeded from the very first sample after reset;
// the dynamic part of every sample is squared, summed over the axes, rounded to Q16.16,
// saturated at 32 bits and forced to zero below the noise floor. A running total covers
// a circular window of window_length samples, and every report_interval samples the mean
// square is compared against the squared on and off levels to update a hysteretic flag.
// Every sample yields exactly one result word. The front part takes a new sample only
// once its multiply, gravity update, square and sum steps have run in sequence; the
// acceptance of the next sample overlaps the sum step while the queue has room. The back
// part steps through fewer states per word for its window store read-modify-write and
// threshold check, so the front sets the sustained rate. Two-entry queues sit between
// the front and back and in front of the result port, so either side may stall.
// Configuration writes are meant for idle periods only; writing window_length restarts
// the window (fill, slot and total cleared) while gravity, the interval count and the
// flag remain.
module vibration_rms_hysteresis_detector import vrhd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  sample_t                sample,
  output logic                   empty,
  input  logic                   pop,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  logic restart;

  logic sq_push;
  square_t sq_word;
  logic sq_full;
  logic sq_pop;
  square_t sq_head;
  logic sq_empty;

  logic res_push;
  result_t res_word;
  logic res_full;

  // Writing the window length empties the window.
  assign restart = cfg_write && (cfg_index == REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity_gain <= GRAVITY_GAIN_RST;
      cfg.noise_floor <= NOISE_FLOOR_RST;
      cfg.on_level_sq <= ON_LEVEL_SQ_RST;
      cfg.off_level_sq <= OFF_LEVEL_SQ_RST;
      cfg.window_length <= WINDOW_LENGTH_RST;
      cfg.report_interval <= REPORT_INTERVAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRAVITY_GAIN:    cfg.gravity_gain <= cfg_data[15:0];
        REG_NOISE_FLOOR:     cfg.noise_floor <= cfg_data;
        REG_ON_LEVEL_SQ:     cfg.on_level_sq <= cfg_data;
        REG_OFF_LEVEL_SQ:    cfg.off_level_sq <= cfg_data;
        REG_WINDOW_LENGTH:   cfg.window_length <= cfg_data[7:0];
        REG_REPORT_INTERVAL: cfg.report_interval <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  vrhd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .sample (sample),
    .full   (full),
    .q_push (sq_push),
    .q_word (sq_word),
    .q_full (sq_full)
  );

  vrhd_fifo #(
    .word_t (square_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_sq_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (sq_push),
    .wdata (sq_word),
    .full  (sq_full),
    .pop   (sq_pop),
    .rdata (sq_head),
    .empty (sq_empty)
  );

  vrhd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .restart  (restart),
    .in_empty (sq_empty),
    .in_word  (sq_head),
    .in_pop   (sq_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_word (res_word)
  );

  vrhd_fifo #(
    .word_t (result_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_word),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
